// ----- hdl/sre_pkg.sv -----
// shared types, codes and constants for the sorted record set engine
// no dependencies; imported by the top level and sre_core (sre_ram does not use it)
`default_nettype none
package sre_pkg;

	localparam int SET_DEPTH_DEF = 32;
	localparam int VALUE_W = 32;

	// operation codes
	localparam logic [2:0] F_CLEAR_A = 3'd0;
	localparam logic [2:0] F_INSERT_A = 3'd1;
	localparam logic [2:0] F_LOAD_B = 3'd2;
	localparam logic [2:0] F_CLEAR_B = 3'd3;
	localparam logic [2:0] F_ISECT = 3'd4;
	localparam logic [2:0] F_UNION = 3'd5;
	localparam logic [2:0] F_READ_A = 3'd6;

	// status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_out;
		logic [1:0]         status;
		logic               last;
		logic [5:0]         count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_ISSUE,
		S_SCAN_CMP,
		S_FULLCHK,
		S_SHIFT_ISSUE,
		S_SHIFT_WR,
		S_INS_DONE,
		S_U_ISSUE,
		S_U_GET,
		S_X_ISSUE,
		S_X_CMP,
		S_R_ISSUE,
		S_R_EMIT,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/sorted_record_set_engine_unit.sv -----
// top level of the sorted record set engine: two set rams, sequencer, output register
// depends on sre_pkg, sre_ram, sre_core
//
//  channel | valid     | ready     | payload            | moves
//  --------+-----------+-----------+--------------------+------------------------------
//  request | req_valid | req_ready | req  (req_item_t)  | one operation item
//  result  | rsp_valid | rsp_ready | rsp  (rsp_item_t)  | one result item, last on final
//
// one item at a time; req_ready is high only while the sequencer is idle
// clear, unused codes, load into a full B, empty readout: a single result item, then idle
// insert into A or load into B: scan read/compare, then shift read/write per entry
// intersect: one merge step per ram read pair
// union: one insert into A per entry of B, A growing as it goes
// readout: one ram read and one emit per entry, plus any stall on the result side
// arst_n clears the state machine and both counts; set contents stay undefined
// a finished result waits in the output register while the next item is already taken
`default_nettype none
module sorted_record_set_engine_unit
	import sre_pkg::*;
#(
	parameter int SET_DEPTH = SET_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

	// sequencer result side
	logic      res_valid, res_ready;
	rsp_item_t res;

	// ram ports for set A and set B
	logic               a_we, a_re, b_we, b_re;
	logic [AW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
	logic [VALUE_W-1:0] a_wdata, a_rdata, b_wdata, b_rdata;

	// output register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	sre_ram #(.WIDTH(VALUE_W), .DEPTH(SET_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	sre_ram #(.WIDTH(VALUE_W), .DEPTH(SET_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	sre_core #(.SET_DEPTH(SET_DEPTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.a_we      (a_we),
		.a_waddr   (a_waddr),
		.a_wdata   (a_wdata),
		.a_re      (a_re),
		.a_raddr   (a_raddr),
		.a_rdata   (a_rdata),
		.b_we      (b_we),
		.b_waddr   (b_waddr),
		.b_wdata   (b_wdata),
		.b_re      (b_re),
		.b_raddr   (b_raddr),
		.b_rdata   (b_rdata)
	);

	// the register takes a new item when empty or being drained this cycle
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted item always keeps the sequencer busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous item still in progress");

	// an empty readout carries zero value and zero count on its only item
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.last && rsp.count == 6'd0 &&
		rsp.value_out == '0)
		else $error("malformed empty readout item");

	// a duplicate or full status comes only on a single-item result
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_DUP || rsp.status == ST_FULL) |-> rsp.last)
		else $error("refusal status on a non-final item");

	// the set never reports more entries than it can hold
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 7'(rsp.count) <= 7'(SET_DEPTH))
		else $error("count beyond set depth");

endmodule
`default_nettype wire

// ----- hdl/sre_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module sre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sre_core.sv -----
// sequencer: walks the two set memories for insert, load, intersect, union, readout
// depends on sre_pkg; drives the ports of two sre_ram instances
`default_nettype none
module sre_core
	import sre_pkg::*;
#(
	parameter int SET_DEPTH = SET_DEPTH_DEF,
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_item_t          req,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output rsp_item_t               res,
	output logic                    a_we,
	output logic [AW-1:0]           a_waddr,
	output logic [VALUE_W-1:0]      a_wdata,
	output logic                    a_re,
	output logic [AW-1:0]           a_raddr,
	input  wire logic [VALUE_W-1:0] a_rdata,
	output logic                    b_we,
	output logic [AW-1:0]           b_waddr,
	output logic [VALUE_W-1:0]      b_wdata,
	output logic                    b_re,
	output logic [AW-1:0]           b_raddr,
	input  wire logic [VALUE_W-1:0] b_rdata
);
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

	state_t state_q, state_d;

	logic [2:0]         func_q;
	logic [VALUE_W-1:0] echo_q, v_q;
	logic [CW-1:0]      idx_q, pos_q, j_q, n_q, cnt_a_q, cnt_b_q;
	logic [1:0]         ins_st_q, ust_q;
	logic               tgt_b_q;

	logic               accept;
	logic [CW-1:0]      cnt_t, idx_m1;
	logic [VALUE_W-1:0] trd;
	logic               eq, lt, at_end, full, dup, ins_here, x_end, r_last;
	logic               t_we, t_re;
	logic [AW-1:0]      t_waddr, t_raddr;
	logic [VALUE_W-1:0] t_wdata;

	assign accept   = req_valid && req_ready;
	assign cnt_t    = tgt_b_q ? cnt_b_q : cnt_a_q;
	assign trd      = tgt_b_q ? b_rdata : a_rdata;
	assign idx_m1   = idx_q - 1'b1;
	assign eq       = (trd == v_q);
	assign lt       = (v_q < trd);
	assign dup      = !tgt_b_q && eq;
	assign at_end   = (idx_q == cnt_t);
	assign full     = (cnt_t >= DEPTH_C);
	assign ins_here = (idx_q == pos_q);
	assign x_end    = (idx_q == cnt_a_q) || (j_q == cnt_b_q);
	assign r_last   = ((idx_q + 1'b1) == cnt_a_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.func)
						F_INSERT_A: state_d = S_SCAN_ISSUE;
						F_LOAD_B:   state_d = (cnt_b_q >= DEPTH_C) ? S_EMIT : S_SCAN_ISSUE;
						F_ISECT:    state_d = S_X_ISSUE;
						F_UNION:    state_d = S_U_ISSUE;
						F_READ_A:   state_d = (cnt_a_q == '0) ? S_EMIT : S_R_ISSUE;
						default:    state_d = S_EMIT;
					endcase
				end
			end
			S_SCAN_ISSUE:  state_d = at_end ? S_FULLCHK : S_SCAN_CMP;
			S_SCAN_CMP:    state_d = dup ? S_INS_DONE : (lt ? S_FULLCHK : S_SCAN_ISSUE);
			S_FULLCHK:     state_d = full ? S_INS_DONE : S_SHIFT_ISSUE;
			S_SHIFT_ISSUE: state_d = ins_here ? S_INS_DONE : S_SHIFT_WR;
			S_SHIFT_WR:    state_d = S_SHIFT_ISSUE;
			S_INS_DONE:    state_d = (func_q == F_UNION) ? S_U_ISSUE : S_EMIT;
			S_U_ISSUE:     state_d = (j_q == cnt_b_q) ? S_EMIT : S_U_GET;
			S_U_GET:       state_d = S_SCAN_ISSUE;
			S_X_ISSUE:     state_d = x_end ? S_EMIT : S_X_CMP;
			S_X_CMP:       state_d = S_X_ISSUE;
			S_R_ISSUE:     state_d = S_R_EMIT;
			S_R_EMIT: begin
				if (res_ready) begin
					state_d = r_last ? S_IDLE : S_R_ISSUE;
				end
			end
			S_EMIT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		t_we      = 1'b0;
		t_re      = 1'b0;
		t_waddr   = '0;
		t_raddr   = '0;
		t_wdata   = '0;
		a_we      = 1'b0;
		a_waddr   = '0;
		a_wdata   = '0;
		a_re      = 1'b0;
		a_raddr   = '0;
		b_we      = 1'b0;
		b_waddr   = '0;
		b_wdata   = '0;
		b_re      = 1'b0;
		b_raddr   = '0;
		unique case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_SCAN_ISSUE: begin
				t_re    = !at_end;
				t_raddr = idx_q[AW-1:0];
			end
			S_SHIFT_ISSUE: begin
				if (ins_here) begin
					t_we    = 1'b1;
					t_waddr = pos_q[AW-1:0];
					t_wdata = v_q;
				end else begin
					t_re    = 1'b1;
					t_raddr = idx_m1[AW-1:0];
				end
			end
			S_SHIFT_WR: begin
				t_we    = 1'b1;
				t_waddr = idx_q[AW-1:0];
				t_wdata = trd;
			end
			S_U_ISSUE: begin
				b_re    = (j_q != cnt_b_q);
				b_raddr = j_q[AW-1:0];
			end
			S_X_ISSUE: begin
				a_re    = !x_end;
				a_raddr = idx_q[AW-1:0];
				b_re    = !x_end;
				b_raddr = j_q[AW-1:0];
			end
			S_X_CMP: begin
				a_we    = (a_rdata == b_rdata);
				a_waddr = n_q[AW-1:0];
				a_wdata = a_rdata;
			end
			S_R_ISSUE: begin
				a_re    = 1'b1;
				a_raddr = idx_q[AW-1:0];
			end
			S_R_EMIT: begin
				res_valid     = 1'b1;
				res.value_out = a_rdata;
				res.status    = ST_DONE;
				res.last      = r_last;
				res.count     = 6'(cnt_a_q);
			end
			S_EMIT: begin
				res_valid     = 1'b1;
				res.value_out = echo_q;
				res.last      = 1'b1;
				res.count     = 6'(cnt_a_q);
				case (func_q) inside
					F_INSERT_A, F_LOAD_B: res.status = ins_st_q;
					F_UNION:              res.status = ust_q;
					F_READ_A: begin
						res.status    = ST_EMPTY;
						res.value_out = '0;
					end
					default:              res.status = ST_DONE;
				endcase
			end
			default: ;
		endcase
		// insert walk goes to whichever set is the target
		if (tgt_b_q) begin
			if (t_we || t_re) begin
				b_we    = t_we;
				b_waddr = t_waddr;
				b_wdata = t_wdata;
				b_re    = t_re;
				b_raddr = t_raddr;
			end
		end else if (t_we || t_re) begin
			a_we    = t_we;
			a_waddr = t_waddr;
			a_wdata = t_wdata;
			a_re    = t_re;
			a_raddr = t_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && req.func == F_CLEAR_A) begin
				cnt_a_q <= '0;
			end
			if (accept && req.func == F_CLEAR_B) begin
				cnt_b_q <= '0;
			end
			if (state_q == S_SHIFT_ISSUE && ins_here) begin
				if (tgt_b_q) begin
					cnt_b_q <= cnt_b_q + 1'b1;
				end else begin
					cnt_a_q <= cnt_a_q + 1'b1;
				end
			end
			if (state_q == S_X_ISSUE && x_end) begin
				cnt_a_q <= n_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q   <= req.func;
					echo_q   <= req.value;
					v_q      <= req.value;
					idx_q    <= '0;
					j_q      <= '0;
					n_q      <= '0;
					ust_q    <= ST_DONE;
					tgt_b_q  <= (req.func == F_LOAD_B);
					ins_st_q <= (req.func == F_LOAD_B && cnt_b_q >= DEPTH_C) ? ST_FULL : ST_DONE;
				end
			end
			S_SCAN_ISSUE: begin
				if (at_end) begin
					pos_q <= idx_q;
				end
			end
			S_SCAN_CMP: begin
				if (dup) begin
					ins_st_q <= ST_DUP;
				end else if (lt) begin
					pos_q <= idx_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_FULLCHK: begin
				if (full) begin
					ins_st_q <= ST_FULL;
				end else begin
					idx_q <= cnt_t;
				end
			end
			S_SHIFT_WR: idx_q <= idx_m1;
			S_INS_DONE: begin
				if (ins_st_q == ST_FULL) begin
					ust_q <= ST_FULL;
				end
				j_q <= j_q + 1'b1;
			end
			S_U_GET: begin
				v_q      <= b_rdata;
				tgt_b_q  <= 1'b0;
				idx_q    <= '0;
				ins_st_q <= ST_DONE;
			end
			S_X_CMP: begin
				if (a_rdata == b_rdata) begin
					n_q   <= n_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end else if (a_rdata < b_rdata) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_R_EMIT: begin
				if (res_ready && !r_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
